// ----- rtl/adsr_pkg.sv -----
package adsr_pkg;

  localparam int GainFracBitsDefault = 16;
  localparam int ModFracBits = 14;
  localparam int StepW = 16;
  localparam int LevelW = 24;
  localparam int ModW = 16;
  localparam int StageW = 2;
  localparam int DataW = 32;
  localparam int AddrW = 5;
  localparam int RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegAttackStep = 3'd0;
  localparam logic [RegIdxW-1:0] RegDecayStep = 3'd1;
  localparam logic [RegIdxW-1:0] RegReleaseStep = 3'd2;
  localparam logic [RegIdxW-1:0] RegPeakLevel = 3'd3;
  localparam logic [RegIdxW-1:0] RegHoldLevel = 3'd4;

  localparam logic [StepW-1:0] AttackStepReset = 16'd164;
  localparam logic [StepW-1:0] DecayStepReset = 16'd16;
  localparam logic [StepW-1:0] ReleaseStepReset = 16'd3;
  localparam logic [LevelW-1:0] PeakLevelReset = 24'd65536;
  localparam logic [LevelW-1:0] HoldLevelReset = 24'd16384;

  localparam logic [StageW-1:0] StIdle = 2'd0;
  localparam logic [StageW-1:0] StAttack = 2'd1;
  localparam logic [StageW-1:0] StDecay = 2'd2;
  localparam logic [StageW-1:0] StRelease = 2'd3;

  typedef struct packed {
    logic [StepW-1:0] attack_step;
    logic [StepW-1:0] decay_step;
    logic [StepW-1:0] release_step;
    logic [LevelW-1:0] peak_level;
    logic [LevelW-1:0] hold_level;
  } cfg_t;

endpackage

// ----- rtl/adsr_cfg.sv -----
module adsr_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adsr_pkg::AddrW-1:0]   paddr,
  input  logic [adsr_pkg::DataW-1:0]   pwdata,
  output logic [adsr_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output adsr_pkg::cfg_t               cfg
);
  import adsr_pkg::*;

  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_step <= AttackStepReset;
      cfg.decay_step <= DecayStepReset;
      cfg.release_step <= ReleaseStepReset;
      cfg.peak_level <= PeakLevelReset;
      cfg.hold_level <= HoldLevelReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegAttackStep: cfg.attack_step <= pwdata[StepW-1:0];
        RegDecayStep: cfg.decay_step <= pwdata[StepW-1:0];
        RegReleaseStep: cfg.release_step <= pwdata[StepW-1:0];
        RegPeakLevel: cfg.peak_level <= pwdata[LevelW-1:0];
        RegHoldLevel: cfg.hold_level <= pwdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegAttackStep: prdata = DataW'(cfg.attack_step);
      RegDecayStep: prdata = DataW'(cfg.decay_step);
      RegReleaseStep: prdata = DataW'(cfg.release_step);
      RegPeakLevel: prdata = DataW'(cfg.peak_level);
      RegHoldLevel: prdata = DataW'(cfg.hold_level);
      default: prdata = '0;
    endcase
  end

endmodule

// ----- rtl/adsr_core.sv -----
module adsr_core #(
  parameter int GAIN_FRAC_BITS = adsr_pkg::GainFracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  adsr_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic signed [adsr_pkg::ModW-1:0] env_mod,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [8+GAIN_FRAC_BITS-1:0]   gain,
  output logic [adsr_pkg::StageW-1:0]   stage
);
  import adsr_pkg::*;

  localparam int GainBits = 8 + GAIN_FRAC_BITS;
  localparam int ProdW = StepW + 1 + ModW;
  localparam int DeltaW = ProdW - ModFracBits;
  localparam int SumW = ((GainBits > DeltaW) ? GainBits : DeltaW) + 2;
  localparam int CmpW = (GainBits > LevelW) ? GainBits : LevelW;

  // Input register.
  logic                   req_valid;
  logic                   req_action;
  logic signed [ModW-1:0] req_env_mod;

  // Envelope state; it doubles as the result register.
  logic [StageW-1:0]   stage_reg;
  logic [GainBits-1:0] gain_reg;
  logic [StageW-1:0]   stage_next;
  logic [GainBits-1:0] gain_next;

  logic                     advance;
  logic [StepW-1:0]         step_sel;
  logic signed [ProdW-1:0]  product;
  logic signed [DeltaW-1:0] delta;
  logic signed [SumW-1:0]   gain_ext;
  logic signed [SumW-1:0]   delta_ext;
  logic signed [SumW-1:0]   sum;
  logic [GainBits-1:0]      sum_clamped;
  logic [CmpW-1:0]          gain_cmp;

  assign advance = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_action <= action;
      req_env_mod <= env_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg <= StIdle;
      gain_reg <= '0;
    end else if (advance) begin
      stage_reg <= stage_next;
      gain_reg <= gain_next;
    end
  end

  // The arithmetic shift of the product floors toward minus infinity.
  assign step_sel = (stage_reg == StAttack) ? cfg.attack_step : cfg.decay_step;
  assign product = $signed({1'b0, step_sel}) * req_env_mod;
  assign delta = product[ProdW-1:ModFracBits];
  assign gain_ext = $signed(SumW'(gain_reg));
  assign delta_ext = {{(SumW-DeltaW){delta[DeltaW-1]}}, delta};
  assign gain_cmp = CmpW'(gain_reg);

  always_comb begin
    case (stage_reg)
      StAttack: sum = gain_ext + delta_ext;
      StDecay: sum = gain_ext - delta_ext;
      default: sum = gain_ext - $signed(SumW'(cfg.release_step));
    endcase
  end

  always_comb begin
    if (sum[SumW-1]) begin
      sum_clamped = '0;
    end else if (|sum[SumW-2:GainBits]) begin
      sum_clamped = '1;
    end else begin
      sum_clamped = sum[GainBits-1:0];
    end
  end

  // A tick that changes the stage leaves the gain where it is.
  always_comb begin
    stage_next = stage_reg;
    gain_next = gain_reg;
    if (req_action) begin
      stage_next = StAttack;
      gain_next = '0;
    end else begin
      case (stage_reg)
        StAttack: begin
          if (gain_cmp >= CmpW'(cfg.peak_level)) begin
            stage_next = StDecay;
          end else begin
            gain_next = sum_clamped;
          end
        end
        StDecay: begin
          if (gain_cmp > CmpW'(cfg.hold_level)) begin
            gain_next = sum_clamped;
          end else begin
            stage_next = StRelease;
          end
        end
        StRelease: begin
          if (gain_reg != '0) begin
            gain_next = sum_clamped;
          end else begin
            stage_next = StIdle;
          end
        end
        default: ;
      endcase
    end
  end

  assign gain = gain_reg;
  assign stage = stage_reg;

endmodule

// ----- rtl/adsr_envelope_generator.sv -----
// Envelope generator with attack, decay and release stages (no sustain stage).
// Each request is either a trigger, which restarts attack at zero gain, or a
// sample tick that advances the envelope using a signed Q2.14 modulation
// factor; every request returns the gain (unsigned, GAIN_FRAC_BITS fraction
// bits, saturating) and the stage that follow it. The update is one 17 by
// 16 bit multiply, an add and a clamp between the input register and the
// envelope state register, so a result is presented from the state register
// after its request has passed the input register, and the block takes one
// request per cycle while the output side keeps up. The step and level
// registers sit on an APB port (attack_step at 0x00, decay_step 0x04,
// release_step 0x08, peak_level 0x0C, hold_level 0x10) and should be written
// only while no request is in flight.
module adsr_envelope_generator #(
  parameter int GAIN_FRAC_BITS = adsr_pkg::GainFracBitsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [adsr_pkg::AddrW-1:0]       paddr,
  input  logic [adsr_pkg::DataW-1:0]       pwdata,
  output logic [adsr_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic signed [adsr_pkg::ModW-1:0] env_mod,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [8+GAIN_FRAC_BITS-1:0]      gain,
  output logic [adsr_pkg::StageW-1:0]      stage
);
  import adsr_pkg::*;

  cfg_t cfg;

  adsr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  adsr_core #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .env_mod   (env_mod),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gain      (gain),
    .stage     (stage)
  );

endmodule
